### design/packed_pixel_alpha_blend_top_assert.svh
// Assertion macros for the packed pixel blend block.
// Used by packed_pixel_alpha_blend_top; needs clk and rst_n in scope.
`ifndef PACKED_PIXEL_ALPHA_BLEND_TOP_ASSERT_SVH
`define PACKED_PIXEL_ALPHA_BLEND_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define PPAB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PPAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ppab_pkg.sv
// Shared types, constants and channel-format helpers for the packed pixel blend.
// No dependencies; used by every module of the block.
package ppab_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SIZE_BITS      = COORD_BITS + 1;
    localparam int PIX_BITS       = 32;
    localparam int HALF_BITS      = 16;
    localparam int CHAN_BITS      = 8;
    localparam int NUM_CH         = 4;
    localparam int FMT_FIELD_BITS = 9;
    localparam int FMT_BITS       = NUM_CH * FMT_FIELD_BITS;
    localparam int SHIFT_BITS     = 5;
    localparam int LOSS_BITS      = 4;
    localparam int INDEX_BITS     = 24;
    localparam int IDX_PROD_BITS  = COORD_BITS + SIZE_BITS + 1;
    localparam int BLEND_SHIFT    = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = FMT_BITS;

    // input request tdata layout, lowest field first
    localparam int COL_LSB      = 0;
    localparam int ROW_LSB      = COL_LSB + COORD_BITS;
    localparam int DEST_LSB     = ROW_LSB + COORD_BITS;
    localparam int RED_LSB      = DEST_LSB + PIX_BITS;
    localparam int GREEN_LSB    = RED_LSB + CHAN_BITS;
    localparam int BLUE_LSB     = GREEN_LSB + CHAN_BITS;
    localparam int ALPHA_LSB    = BLUE_LSB + CHAN_BITS;
    localparam int IN_RAW_BITS  = ALPHA_LSB + CHAN_BITS;
    localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;

    // result tdata layout
    localparam int OUT_RAW_BITS  = INDEX_BITS + PIX_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hff;

    typedef logic [PIX_BITS-1:0] word_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WIDE_PIXELS    = 3'd0,
        REG_CHANNEL_FORMAT = 3'd1,
        REG_CLIP_LEFT      = 3'd2,
        REG_CLIP_TOP       = 3'd3,
        REG_CLIP_WIDTH     = 3'd4,
        REG_CLIP_HEIGHT    = 3'd5,
        REG_LINE_PITCH     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                  wide_pixels;
        logic [FMT_BITS-1:0]   channel_format;
        logic [COORD_BITS-1:0] clip_left;
        logic [COORD_BITS-1:0] clip_top;
        logic [SIZE_BITS-1:0]  clip_width;
        logic [SIZE_BITS-1:0]  clip_height;
        logic [SIZE_BITS-1:0]  line_pitch;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        wide_pixels:    1'b1,
        channel_format: 36'hC0001010,
        clip_left:      '0,
        clip_top:       '0,
        clip_width:     SIZE_BITS'(2 ** COORD_BITS),
        clip_height:    SIZE_BITS'(2 ** COORD_BITS),
        line_pitch:     SIZE_BITS'(2 ** COORD_BITS)
    };

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        word_t                 dest_pixel;
        logic [CHAN_BITS-1:0]  red;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  blue;
        logic [CHAN_BITS-1:0]  alpha;
        logic                  force_copy;
    } item_t;

    // after clip test, packing and channel differences
    typedef struct packed {
        logic                     in_clip;
        logic                     copy;
        logic [CHAN_BITS-1:0]     alpha;
        word_t                    color;
        word_t [NUM_CH-1:0]       dm;
        word_t [NUM_CH-1:0]       diff;
        logic [COORD_BITS-1:0]    column;
        logic [COORD_BITS-1:0]    row;
    } st1_t;

    // after the multipliers
    typedef struct packed {
        logic                     in_clip;
        logic                     copy;
        word_t                    color;
        word_t [NUM_CH-1:0]       dm;
        word_t [NUM_CH-1:0]       prod;
        logic [INDEX_BITS-1:0]    index;
    } st2_t;

    typedef struct packed {
        logic                  written;
        logic [INDEX_BITS-1:0] pixel_index;
        word_t                 new_pixel;
    } res_t;

    function automatic logic [SHIFT_BITS-1:0] chan_shift(logic [FMT_BITS-1:0] fmt, int ch);
        return fmt[ch * FMT_FIELD_BITS +: SHIFT_BITS];
    endfunction

    function automatic logic [LOSS_BITS-1:0] chan_loss(logic [FMT_BITS-1:0] fmt, int ch);
        return fmt[ch * FMT_FIELD_BITS + SHIFT_BITS +: LOSS_BITS];
    endfunction

    // (0xff >> loss) << shift, kept to the pixel word
    function automatic word_t chan_mask(logic [FMT_BITS-1:0] fmt, int ch);
        word_t base;
        base = {{(PIX_BITS - CHAN_BITS){1'b0}}, ({CHAN_BITS{1'b1}} >> chan_loss(fmt, ch))};
        return base << chan_shift(fmt, ch);
    endfunction

endpackage

### design/ppab_front.sv
// Stage 1: clip test, colour packing, masked destination and channel differences.
// Depends on ppab_pkg.
module ppab_front (
    input  logic            clk,
    input  logic            rst_n,
    input  ppab_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  ppab_pkg::item_t in_item,
    output logic            in_ready,
    output logic            out_valid,
    output ppab_pkg::st1_t  out_data,
    input  logic            out_ready
);

    logic                            valid_reg;
    logic                            valid_next;
    ppab_pkg::st1_t                  data_reg;
    ppab_pkg::st1_t                  data_next;
    ppab_pkg::word_t                 dest_eff;
    ppab_pkg::word_t                 color;
    ppab_pkg::word_t                 mask_v [ppab_pkg::NUM_CH];
    ppab_pkg::word_t                 cm_v   [ppab_pkg::NUM_CH];
    ppab_pkg::word_t                 sub_v  [ppab_pkg::NUM_CH];
    logic [ppab_pkg::CHAN_BITS-1:0]  src    [ppab_pkg::NUM_CH];
    logic                            col_ok;
    logic                            row_ok;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign src[0] = in_item.red;
    assign src[1] = in_item.green;
    assign src[2] = in_item.blue;
    assign src[3] = in_item.alpha;

    // sums carry one extra bit so a full-size rectangle does not wrap
    assign col_ok = (in_item.column >= cfg.clip_left) &&
        ((ppab_pkg::SIZE_BITS + 1)'(in_item.column) <
         (ppab_pkg::SIZE_BITS + 1)'(cfg.clip_left) + (ppab_pkg::SIZE_BITS + 1)'(cfg.clip_width));
    assign row_ok = (in_item.row >= cfg.clip_top) &&
        ((ppab_pkg::SIZE_BITS + 1)'(in_item.row) <
         (ppab_pkg::SIZE_BITS + 1)'(cfg.clip_top) + (ppab_pkg::SIZE_BITS + 1)'(cfg.clip_height));

    always_comb
    begin
        dest_eff = in_item.dest_pixel;
        if (!cfg.wide_pixels)
        begin
            dest_eff[ppab_pkg::PIX_BITS-1:ppab_pkg::HALF_BITS] = '0;
        end
        color = '0;
        for (int ch = 0; ch < ppab_pkg::NUM_CH; ch++)
        begin
            mask_v[ch] = ppab_pkg::chan_mask(cfg.channel_format, ch);
            color = color |
                ((ppab_pkg::word_t'(src[ch]) >> ppab_pkg::chan_loss(cfg.channel_format, ch))
                 << ppab_pkg::chan_shift(cfg.channel_format, ch));
        end
        data_next         = data_reg;
        data_next.in_clip = col_ok && row_ok;
        data_next.copy    = (in_item.alpha == ppab_pkg::ALPHA_OPAQUE) || in_item.force_copy;
        data_next.alpha   = in_item.alpha;
        data_next.color   = color;
        data_next.column  = in_item.column;
        data_next.row     = in_item.row;
        for (int ch = 0; ch < ppab_pkg::NUM_CH; ch++)
        begin
            cm_v[ch]          = color & mask_v[ch];
            data_next.dm[ch]  = dest_eff & mask_v[ch];
            sub_v[ch]         = cm_v[ch] - data_next.dm[ch];
            // wide pixels: difference is brought down to bit 0 first
            data_next.diff[ch] = cfg.wide_pixels ?
                (sub_v[ch] >> ppab_pkg::chan_shift(cfg.channel_format, ch)) : sub_v[ch];
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/ppab_mult.sv
// Stage 2: per-channel difference times alpha and the pixel word index.
// Depends on ppab_pkg.
module ppab_mult (
    input  logic           clk,
    input  logic           rst_n,
    input  ppab_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  ppab_pkg::st1_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output ppab_pkg::st2_t out_data,
    input  logic           out_ready
);

    logic           valid_reg;
    logic           valid_next;
    ppab_pkg::st2_t data_reg;
    ppab_pkg::st2_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next         = data_reg;
        data_next.in_clip = in_data.in_clip;
        data_next.copy    = in_data.copy;
        data_next.color   = in_data.color;
        data_next.dm      = in_data.dm;
        // 32 x 8 product, wraps at 32 bits
        for (int ch = 0; ch < ppab_pkg::NUM_CH; ch++)
        begin
            data_next.prod[ch] = in_data.diff[ch] * ppab_pkg::word_t'(in_data.alpha);
        end
        data_next.index = ppab_pkg::INDEX_BITS'(
            ppab_pkg::IDX_PROD_BITS'(in_data.row) * ppab_pkg::IDX_PROD_BITS'(cfg.line_pitch) +
            ppab_pkg::IDX_PROD_BITS'(in_data.column));
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/ppab_back.sv
// Stage 3: scale back, add to destination, merge channels, copy select and clip zeroing.
// Depends on ppab_pkg.
module ppab_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ppab_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  ppab_pkg::st2_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output ppab_pkg::res_t out_data,
    input  logic           out_ready
);

    logic            valid_reg;
    logic            valid_next;
    ppab_pkg::res_t  data_reg;
    ppab_pkg::res_t  data_next;
    ppab_pkg::word_t part_v [ppab_pkg::NUM_CH];
    ppab_pkg::word_t blend;
    ppab_pkg::word_t px;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        blend = '0;
        for (int ch = 0; ch < ppab_pkg::NUM_CH; ch++)
        begin
            part_v[ch] = in_data.prod[ch] >> ppab_pkg::BLEND_SHIFT;
            if (cfg.wide_pixels)
            begin
                part_v[ch] = part_v[ch] << ppab_pkg::chan_shift(cfg.channel_format, ch);
            end
            // an empty mask (missing alpha) drops out here
            blend = blend | ((in_data.dm[ch] + part_v[ch]) &
                             ppab_pkg::chan_mask(cfg.channel_format, ch));
        end
        px = in_data.copy ? in_data.color : blend;
        if (!cfg.wide_pixels)
        begin
            px[ppab_pkg::PIX_BITS-1:ppab_pkg::HALF_BITS] = '0;
        end
        data_next.written     = in_data.in_clip;
        data_next.pixel_index = in_data.in_clip ? in_data.index : '0;
        data_next.new_pixel   = in_data.in_clip ? px : '0;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/packed_pixel_alpha_blend_top.sv
// Packed RGBA pixel alpha blend, top level: config registers, three stages, output buffer.
// Results pass the three stage registers, then the output buffer. Throughput: one
// request per clock unless stalled; a two-entry output buffer keeps s_axis_tready off m_axis_tready.
// Reset: registers return to ARGB 8888, 32-bit pixels, full 4096 x 4096 clip, pitch 4096;
// all valid bits clear. No memories, no clearing pass. Depends on ppab_pkg and the assert header.
`include "packed_pixel_alpha_blend_top_assert.svh"

module packed_pixel_alpha_blend_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ppab_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // column, row, dest_pixel, red, green, blue, alpha
    input  logic [ppab_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // force_copy
    input  logic                                s_axis_tuser,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_index, new_pixel
    output logic [ppab_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // written
    output logic                                m_axis_tuser
);

    ppab_pkg::cfg_t  cfg_reg;
    ppab_pkg::cfg_t  cfg_next;
    ppab_pkg::item_t in_item;

    logic            st1_valid;
    logic            st1_ready;
    ppab_pkg::st1_t  st1_data;
    logic            st2_valid;
    logic            st2_ready;
    ppab_pkg::st2_t  st2_data;
    logic            st3_valid;
    ppab_pkg::res_t  st3_data;

    logic            main_valid_reg;
    logic            main_valid_next;
    logic            spare_valid_reg;
    logic            spare_valid_next;
    ppab_pkg::res_t  main_data_reg;
    ppab_pkg::res_t  main_data_next;
    ppab_pkg::res_t  spare_data_reg;
    ppab_pkg::res_t  spare_data_next;
    logic            skid_ready;
    logic            push;
    logic            pop;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (ppab_pkg::cfg_reg_t'(cfg_index))
                ppab_pkg::REG_WIDE_PIXELS:
                    cfg_next.wide_pixels = cfg_data[0];
                ppab_pkg::REG_CHANNEL_FORMAT:
                    cfg_next.channel_format = cfg_data[ppab_pkg::FMT_BITS-1:0];
                ppab_pkg::REG_CLIP_LEFT:
                    cfg_next.clip_left = cfg_data[ppab_pkg::COORD_BITS-1:0];
                ppab_pkg::REG_CLIP_TOP:
                    cfg_next.clip_top = cfg_data[ppab_pkg::COORD_BITS-1:0];
                ppab_pkg::REG_CLIP_WIDTH:
                    cfg_next.clip_width = cfg_data[ppab_pkg::SIZE_BITS-1:0];
                ppab_pkg::REG_CLIP_HEIGHT:
                    cfg_next.clip_height = cfg_data[ppab_pkg::SIZE_BITS-1:0];
                ppab_pkg::REG_LINE_PITCH:
                    cfg_next.line_pitch = cfg_data[ppab_pkg::SIZE_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ppab_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- request unpack ----------------
    assign in_item.column     = s_axis_tdata[ppab_pkg::COL_LSB +: ppab_pkg::COORD_BITS];
    assign in_item.row        = s_axis_tdata[ppab_pkg::ROW_LSB +: ppab_pkg::COORD_BITS];
    assign in_item.dest_pixel = s_axis_tdata[ppab_pkg::DEST_LSB +: ppab_pkg::PIX_BITS];
    assign in_item.red        = s_axis_tdata[ppab_pkg::RED_LSB +: ppab_pkg::CHAN_BITS];
    assign in_item.green      = s_axis_tdata[ppab_pkg::GREEN_LSB +: ppab_pkg::CHAN_BITS];
    assign in_item.blue       = s_axis_tdata[ppab_pkg::BLUE_LSB +: ppab_pkg::CHAN_BITS];
    assign in_item.alpha      = s_axis_tdata[ppab_pkg::ALPHA_LSB +: ppab_pkg::CHAN_BITS];
    assign in_item.force_copy = s_axis_tuser;

    // ---------------- pipeline ----------------
    ppab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .in_ready  (s_axis_tready),
        .out_valid (st1_valid),
        .out_data  (st1_data),
        .out_ready (st1_ready)
    );

    ppab_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (st1_valid),
        .in_data   (st1_data),
        .in_ready  (st1_ready),
        .out_valid (st2_valid),
        .out_data  (st2_data),
        .out_ready (st2_ready)
    );

    ppab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (st2_valid),
        .in_data   (st2_data),
        .in_ready  (st2_ready),
        .out_valid (st3_valid),
        .out_data  (st3_data),
        .out_ready (skid_ready)
    );

    // ---------------- output buffer ----------------
    // ready toward the pipeline depends only on the spare entry
    assign skid_ready = !spare_valid_reg;
    assign push       = st3_valid && skid_ready;
    assign pop        = main_valid_reg && m_axis_tready;

    always_comb
    begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_data_next   = main_data_reg;
        spare_data_next  = spare_data_reg;
        if (spare_valid_reg)
        begin
            if (pop)
            begin
                main_data_next   = spare_data_reg;
                spare_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = st3_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                spare_data_next  = st3_data;
                spare_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg  <= main_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tuser  = main_data_reg.written;
    assign m_axis_tdata  = ppab_pkg::OUT_DATA_BITS'({main_data_reg.new_pixel,
                                                    main_data_reg.pixel_index});

    // ---------------- assertions ----------------
    `PPAB_ASSERT_SAME(a_reject_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
        "rejected pixel carries nonzero payload")
    `PPAB_ASSERT_SAME(a_spare_order, spare_valid_reg, main_valid_reg,
        "spare entry full while main entry empty")
    `PPAB_ASSERT_SAME(a_stall_full, !s_axis_tready, st1_valid,
        "input stalled with stage 1 empty")
    `PPAB_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, st1_valid,
        "accepted request missing from stage 1")
    `PPAB_ASSERT_NEXT(a_stage3_hold, st3_valid && !skid_ready, st3_valid,
        "stage 3 result dropped while buffer full")

endmodule

### tb/packed_pixel_alpha_blend_top_test.sv
// Self-checking bench for packed_pixel_alpha_blend_top: clip, pack, copy and blend.
// Runs directed and random pixel requests under random stalls and checks every result
// against its own blend predictor. Needs ppab_pkg and the block's RTL.
module packed_pixel_alpha_blend_top_test;

    import ppab_pkg::*;

    localparam int PIPE_LATENCY  = 4;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 13;
    localparam int RANDOM_SETUPS = 8;
    localparam int SETUP_PIXELS  = 135;
    localparam int MAX_COORD     = (1 << COORD_BITS) - 1;
    localparam int FULL_SPAN     = 1 << COORD_BITS;

    // field = {loss[3:0], shift[4:0]} per channel, red lowest
    localparam logic [FMT_BITS-1:0] FMT_ARGB8888 = 36'h0C0001010;
    localparam logic [FMT_BITS-1:0] FMT_RGB565   = 36'h801808A6B;  // alpha dropped

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;

    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tuser;

    packed_pixel_alpha_blend_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    cfg_t  model_cfg = CFG_RESET;
    item_t pixel_backlog[$];
    res_t  blends_due[$];

    int pixels_queued = 0;
    int pixels_taken  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int setups_done   = 0;

    logic req_fired = 1'b0;
    logic rsp_fired = 1'b0;
    logic src_gaps_on = 1'b0;
    logic snk_gaps_on = 1'b0;
    int   hold_asked = 0;

    // expected result of one pixel request under the current register copy
    function automatic res_t blend_pixel(item_t it);
        res_t             r;
        word_t            msk [NUM_CH];
        logic [4:0]       sh [NUM_CH];
        logic [3:0]       ls [NUM_CH];
        logic [7:0]       chan [NUM_CH];
        logic [8:0]       fld;
        word_t            src, dst, px, cm, dm, diff, prod, a32;
        int               col, row;
        longint           idx;
        r   = '0;
        col = int'(it.column);
        row = int'(it.row);
        if (col < int'(model_cfg.clip_left) ||
            col >= int'(model_cfg.clip_left) + int'(model_cfg.clip_width) ||
            row < int'(model_cfg.clip_top) ||
            row >= int'(model_cfg.clip_top) + int'(model_cfg.clip_height))
            return r;
        chan = '{it.red, it.green, it.blue, it.alpha};
        src = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            fld     = model_cfg.channel_format[ch * FMT_FIELD_BITS +: FMT_FIELD_BITS];
            sh[ch]  = fld[4:0];
            ls[ch]  = fld[8:5];
            msk[ch] = (word_t'(8'hff) >> ls[ch]) << sh[ch];
            src    |= ((word_t'(chan[ch]) >> ls[ch]) << sh[ch]) & msk[ch];
        end
        dst = it.dest_pixel;
        if (!model_cfg.wide_pixels)
            dst &= 32'h0000ffff;
        if (it.alpha == ALPHA_OPAQUE || it.force_copy)
        begin
            px = src;
        end
        else
        begin
            px  = '0;
            a32 = word_t'(it.alpha);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                // no alpha bits in the format: alpha result stays zero
                if (ch == NUM_CH - 1 && msk[ch] == '0)
                    continue;
                cm   = src & msk[ch];
                dm   = dst & msk[ch];
                diff = cm - dm;
                if (model_cfg.wide_pixels)
                    diff = diff >> sh[ch];
                prod = diff * a32;
                prod = prod >> BLEND_SHIFT;
                if (model_cfg.wide_pixels)
                    prod = prod << sh[ch];
                px |= (dm + prod) & msk[ch];
            end
        end
        if (!model_cfg.wide_pixels)
            px &= 32'h0000ffff;
        idx           = longint'(it.row) * longint'(model_cfg.line_pitch) + longint'(it.column);
        r.written     = 1'b1;
        r.pixel_index = idx[INDEX_BITS-1:0];
        r.new_pixel   = px;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("t=%0t mismatch: %s", $time, what);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WIDE_PIXELS:    model_cfg.wide_pixels    = val[0];
            REG_CHANNEL_FORMAT: model_cfg.channel_format = val[FMT_BITS-1:0];
            REG_CLIP_LEFT:      model_cfg.clip_left      = val[COORD_BITS-1:0];
            REG_CLIP_TOP:       model_cfg.clip_top       = val[COORD_BITS-1:0];
            REG_CLIP_WIDTH:     model_cfg.clip_width     = val[SIZE_BITS-1:0];
            REG_CLIP_HEIGHT:    model_cfg.clip_height    = val[SIZE_BITS-1:0];
            REG_LINE_PITCH:     model_cfg.line_pitch     = val[SIZE_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setup(input logic wide, input logic [FMT_BITS-1:0] fmt,
                               input int left, input int top, input int w, input int h,
                               input int pitch);
        write_reg(REG_WIDE_PIXELS, CFG_DATA_BITS'(wide));
        write_reg(REG_CHANNEL_FORMAT, CFG_DATA_BITS'(fmt));
        write_reg(REG_CLIP_LEFT, CFG_DATA_BITS'(left));
        write_reg(REG_CLIP_TOP, CFG_DATA_BITS'(top));
        write_reg(REG_CLIP_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_CLIP_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(REG_LINE_PITCH, CFG_DATA_BITS'(pitch));
        setups_done++;
    endtask

    task automatic queue_pixel(input int col, input int row,
                               input word_t dest, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] a, input logic cp);
        item_t it;
        it.column     = COORD_BITS'(col);
        it.row        = COORD_BITS'(row);
        it.dest_pixel = dest;
        it.red        = r;
        it.green      = g;
        it.blue       = b;
        it.alpha      = a;
        it.force_copy = cp;
        pixel_backlog.push_back(it);
        pixels_queued++;
    endtask

    // registers are only touched once every request has come back
    task automatic wait_drained();
        @(negedge clk);
        while (pixels_taken != pixels_queued || blends_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // mostly inside the clip span, some on its edges, some anywhere
    function automatic int pick_coord(int lo, int span);
        int hi, pick;
        hi = lo + span - 1;
        if (hi > MAX_COORD)
            hi = MAX_COORD;
        case ($urandom_range(0, 7))
            0: pick = $urandom_range(0, MAX_COORD);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: pick = lo - 1;
                    1: pick = lo;
                    2: pick = hi;
                    default: pick = hi + 1;
                endcase
            end
            default:
            begin
                if (hi >= lo)
                    pick = $urandom_range(lo, hi);
                else
                    pick = $urandom_range(0, MAX_COORD);
            end
        endcase
        if (pick < 0)
            pick = 0;
        if (pick > MAX_COORD)
            pick = MAX_COORD;
        return pick;
    endfunction

    // request driver
    item_t next_req;
    int    src_wait = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else if (!s_axis_tvalid || req_fired)
        begin
            if (req_fired)
                src_wait = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (src_wait > 0)
            begin
                src_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                next_req = pixel_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_req.alpha, next_req.blue, next_req.green, next_req.red,
                                  next_req.dest_pixel, next_req.row, next_req.column};
                s_axis_tuser  <= next_req.force_copy;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: per-result stall, plus a long hold-off on demand
    int snk_stall = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (rsp_fired)
                snk_stall = snk_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (snk_stall > 0)
            begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on request, compare on result
    always @(posedge clk)
    begin : port_monitor
        item_t req;
        res_t  got, want;
        req_fired <= rst_n && s_axis_tvalid && s_axis_tready;
        rsp_fired <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            req.column     = s_axis_tdata[COL_LSB +: COORD_BITS];
            req.row        = s_axis_tdata[ROW_LSB +: COORD_BITS];
            req.dest_pixel = s_axis_tdata[DEST_LSB +: PIX_BITS];
            req.red        = s_axis_tdata[RED_LSB +: CHAN_BITS];
            req.green      = s_axis_tdata[GREEN_LSB +: CHAN_BITS];
            req.blue       = s_axis_tdata[BLUE_LSB +: CHAN_BITS];
            req.alpha      = s_axis_tdata[ALPHA_LSB +: CHAN_BITS];
            req.force_copy = s_axis_tuser;
            blends_due.push_back(blend_pixel(req));
            pixels_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.written     = m_axis_tuser;
            got.pixel_index = m_axis_tdata[0 +: INDEX_BITS];
            got.new_pixel   = m_axis_tdata[INDEX_BITS +: PIX_BITS];
            if (blends_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end
            else
            begin
                want = blends_due.pop_front();
                if (got.written !== want.written)
                    report_mismatch($sformatf("result %0d written %0b, expected %0b",
                                              results_seen, got.written, want.written));
                if (got.pixel_index !== want.pixel_index)
                    report_mismatch($sformatf("result %0d pixel_index %0h, expected %0h",
                                              results_seen, got.pixel_index,
                                              want.pixel_index));
                if (got.new_pixel !== want.new_pixel)
                    report_mismatch($sformatf("result %0d new_pixel %h, expected %h",
                                              results_seen, got.new_pixel, want.new_pixel));
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no request accepted for %0d cycles", QUIET_LIMIT);
        $display("packed_pixel_alpha_blend_top_test: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic                wide;
        logic [FMT_BITS-1:0] fmt;
        int                  left, top, w, h, pitch;
        logic [7:0]          a;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup: 32-bit ARGB, full clip
        queue_pixel(0, 0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(MAX_COORD, MAX_COORD, 32'hffffffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
        queue_pixel(1, 2, 32'h12345678, 8'h80, 8'h40, 8'h20, 8'h80, 1'b0);
        queue_pixel(5, 5, 32'hdeadbeef, 8'h10, 8'h20, 8'h30, 8'h7f, 1'b1);
        queue_pixel(MAX_COORD, 0, 32'h0, 8'hff, 8'hff, 8'hff, 8'hfe, 1'b0);
        // source below destination: channel difference wraps
        queue_pixel(0, MAX_COORD, 32'hffffffff, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
        wait_drained();

        // 16-bit RGB565 with no alpha bits, small clip window
        apply_setup(1'b0, FMT_RGB565, 100, 50, 64, 32, 640);
        queue_pixel(99, 60, 32'h1234, 8'h55, 8'h66, 8'h77, 8'h40, 1'b0);
        queue_pixel(100, 50, 32'h1234, 8'h55, 8'h66, 8'h77, 8'h40, 1'b0);
        queue_pixel(163, 81, 32'hffff0000, 8'hff, 8'h00, 8'hff, 8'hc0, 1'b0);
        queue_pixel(164, 60, 32'h1234, 8'h55, 8'h66, 8'h77, 8'h40, 1'b0);
        queue_pixel(120, 82, 32'h1234, 8'h55, 8'h66, 8'h77, 8'h40, 1'b0);
        queue_pixel(120, 49, 32'h1234, 8'h55, 8'h66, 8'h77, 8'h40, 1'b0);
        queue_pixel(130, 70, 32'hffffabcd, 8'hff, 8'h00, 8'h80, 8'h80, 1'b0);
        queue_pixel(131, 70, 32'hffff0000, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
        wait_drained();

        // overlapping masks, clip pinned to the far corner, index wraps
        apply_setup(1'b1, '0, MAX_COORD, MAX_COORD, FULL_SPAN, FULL_SPAN, 8191);
        queue_pixel(MAX_COORD, MAX_COORD, 32'h89abcdef, 8'h12, 8'h34, 8'h56, 8'h40, 1'b0);
        queue_pixel(MAX_COORD - 1, MAX_COORD, 32'h89abcdef, 8'h12, 8'h34, 8'h56, 8'h40, 1'b0);
        queue_pixel(MAX_COORD, MAX_COORD, 32'h89abcdef, 8'h12, 8'h34, 8'h56, 8'h40, 1'b1);
        wait_drained();

        // empty clip window rejects everything
        apply_setup(1'b1, FMT_ARGB8888, 0, 0, 0, 0, FULL_SPAN);
        queue_pixel(0, 0, 32'h11111111, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
        wait_drained();

        // pitch zero, all channels lost
        apply_setup(1'b1, {FMT_BITS{1'b1}}, 0, 0, FULL_SPAN, FULL_SPAN, 0);
        queue_pixel(77, 300, 32'hcafef00d, 8'hab, 8'hcd, 8'hef, 8'hff, 1'b0);
        queue_pixel(MAX_COORD, MAX_COORD, 32'hcafef00d, 8'hab, 8'hcd, 8'hef, 8'h33, 1'b0);
        wait_drained();

        for (int ph = 0; ph < RANDOM_SETUPS; ph++)
        begin
            wide = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: fmt = FMT_ARGB8888;
                1: fmt = FMT_RGB565;
                2:
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                        fmt[ch * FMT_FIELD_BITS +: FMT_FIELD_BITS] =
                            {4'($urandom_range(0, 8)), 5'($urandom_range(0, 31))};
                end
                default: fmt = {4'($urandom_range(0, 15)), $urandom()};
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    left = 0;
                    top  = 0;
                    w    = FULL_SPAN;
                    h    = FULL_SPAN;
                end
                1:
                begin
                    left = $urandom_range(0, MAX_COORD);
                    top  = $urandom_range(0, MAX_COORD);
                    w    = $urandom_range(1, 600);
                    h    = $urandom_range(1, 600);
                end
                2:
                begin
                    left = $urandom_range(MAX_COORD - 600, MAX_COORD);
                    top  = $urandom_range(0, 600);
                    w    = FULL_SPAN;
                    h    = $urandom_range(0, FULL_SPAN);
                end
                default:
                begin
                    left = $urandom_range(0, MAX_COORD);
                    top  = $urandom_range(0, MAX_COORD);
                    w    = $urandom_range(0, FULL_SPAN);
                    h    = $urandom_range(0, FULL_SPAN);
                end
            endcase
            case ($urandom_range(0, 2))
                0: pitch = FULL_SPAN;
                1: pitch = 1;
                default: pitch = $urandom_range(1, FULL_SPAN);
            endcase
            apply_setup(wide, fmt, left, top, w, h, pitch);

            // first setup at full rate, a later one fills the block against a stalled sink
            if (ph == 0 || ph == 3)
            begin
                src_gaps_on = 1'b0;
                snk_gaps_on = 1'b0;
            end
            else
            begin
                src_gaps_on = 1'($urandom_range(0, 1));
                snk_gaps_on = 1'($urandom_range(0, 1));
            end
            if (ph == 3)
                hold_asked++;

            repeat (SETUP_PIXELS)
            begin
                case ($urandom_range(0, 7))
                    0, 1: a = ALPHA_OPAQUE;
                    2: a = 8'h00;
                    default: a = 8'($urandom_range(0, 255));
                endcase
                queue_pixel(pick_coord(left, w), pick_coord(top, h), $urandom(),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), a, $urandom_range(0, 7) == 0);
            end
            wait_drained();
        end

        repeat (4 * PIPE_LATENCY) @(negedge clk);
        if (blends_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", blends_due.size()));
        $display("%0d pixel requests over %0d register setups, %0d results compared",
                 pixels_taken, setups_done, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("packed_pixel_alpha_blend_top_test: clean");
        else
            $display("packed_pixel_alpha_blend_top_test: errors");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/ppab_pkg.sv
design/ppab_front.sv
design/ppab_mult.sv
design/ppab_back.sv
design/packed_pixel_alpha_blend_top.sv
tb/packed_pixel_alpha_blend_top_test.sv
